FILE: hdl/rotation_matrix_to_zyz_euler_macros.svh
// Assertion macros for the rotation matrix to ZYZ Euler angle block.
// Used by the top level; relies on i_clk and i_rst_n in the including scope.
`ifndef ROTATION_MATRIX_TO_ZYZ_EULER_MACROS_SVH
`define ROTATION_MATRIX_TO_ZYZ_EULER_MACROS_SVH

// Check a property while out of reset
`define RMZ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property at every edge, reset included
`define RMZ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: hdl/rmz_pkg.sv
// Shared types, constants and arithmetic helpers for the ZYZ Euler angle block.
// No dependencies; imported by every module of the block.
package rmz_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int ANG_LEN       = 24;
    localparam int STAGE_W       = $clog2(ANG_LEN);
    localparam int SQRT_STEPS    = 16;
    localparam int SQRT_W        = $clog2(SQRT_STEPS);
    localparam int SQ_REM_W      = 18;
    localparam int XY_W          = 28;
    localparam int Z_W           = 24;
    localparam int IN_DATA_W     = 112;
    localparam int OUT_DATA_W    = 56;
    localparam int THR_W         = 13;

    localparam logic signed [Z_W-1:0] PI_Q20 = Z_W'(3294199);
    localparam logic signed [15:0]    PI_Q13 = 16'sd25736;

    typedef enum logic [1:0] {
        LOCK_NONE = 2'd0,
        LOCK_ZERO = 2'd1,
        LOCK_PI   = 2'd2
    } t_lock;

    // One CORDIC lane: vector, angle accumulator, zero-vector flag
    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   zero;
    } t_lane;

    typedef struct packed {
        logic signed [15:0] m00;
        logic signed [15:0] m02;
        logic signed [15:0] m10;
        logic signed [15:0] m12;
        logic signed [15:0] m20;
        logic signed [15:0] m21;
        logic signed [15:0] m22;
    } t_mat;

    // Angle step atan(2^-i) in 2^-20 rad
    function automatic logic signed [Z_W-1:0] atan_step(input logic [STAGE_W-1:0] i);
        logic signed [Z_W-1:0] v;
        case (i)
            5'd0:  v = Z_W'(823550);
            5'd1:  v = Z_W'(486170);
            5'd2:  v = Z_W'(256879);
            5'd3:  v = Z_W'(130396);
            5'd4:  v = Z_W'(65451);
            5'd5:  v = Z_W'(32757);
            5'd6:  v = Z_W'(16383);
            5'd7:  v = Z_W'(8192);
            5'd8:  v = Z_W'(4096);
            5'd9:  v = Z_W'(2048);
            5'd10: v = Z_W'(1024);
            5'd11: v = Z_W'(512);
            5'd12: v = Z_W'(256);
            5'd13: v = Z_W'(128);
            5'd14: v = Z_W'(64);
            5'd15: v = Z_W'(32);
            5'd16: v = Z_W'(16);
            5'd17: v = Z_W'(8);
            5'd18: v = Z_W'(4);
            5'd19: v = Z_W'(2);
            5'd20: v = Z_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

    // Scale operands and fold the left half plane onto the right
    function automatic t_lane lane_init(input logic signed [16:0] y,
                                        input logic signed [16:0] x);
        t_lane l;
        l.zero = (x == 17'sd0) && (y == 17'sd0);
        l.x    = XY_W'(x) <<< 8;
        l.y    = XY_W'(y) <<< 8;
        l.z    = '0;
        if (x < 17'sd0) begin
            l.z = (y >= 17'sd0) ? PI_Q20 : -PI_Q20;
            l.x = -l.x;
            l.y = -l.y;
        end
        return l;
    endfunction

    // Round the accumulator to Q2.13 and saturate to +-pi
    function automatic logic signed [15:0] lane_angle(input t_lane l);
        logic signed [Z_W:0]   zr;
        logic signed [Z_W-7:0] q;
        logic signed [15:0]    r;
        zr = (Z_W+1)'(l.z) + (Z_W+1)'(64);
        q  = (Z_W-6)'(zr >>> 7);
        if (l.zero)
            r = '0;
        else if (q > (Z_W-6)'(PI_Q13))
            r = PI_Q13;
        else if (q < -(Z_W-6)'(PI_Q13))
            r = -PI_Q13;
        else
            r = q[15:0];
        return r;
    endfunction

endpackage

FILE: hdl/rotation_matrix_to_zyz_euler.sv
// Rotation matrix to ZYZ Euler angles. Takes one Q1.14 matrix transaction per cycle while the
// output is not stalled and returns first, middle and last angles in Q2.13 radians plus a
// gimbal-lock code. Stages: one squaring stage, a 16-cell root chain, a lane setup stage,
// five parallel CORDIC lanes and the output register. The whole pipe advances together;
// it stalls only while a result waits at the output.
`include "rotation_matrix_to_zyz_euler_macros.svh"
module rotation_matrix_to_zyz_euler (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // m00, m02, m10, m12, m20, m21, m22, 16 bits each from bit 0
    input  logic [rmz_pkg::IN_DATA_W-1:0]    i_s_tdata,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // first_angle[15:0], middle_angle[30:16], last_angle[46:31], lock_case[48:47]
    output logic [rmz_pkg::OUT_DATA_W-1:0]   o_m_tdata,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [2:0]                       paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import rmz_pkg::*;

    localparam int NL = 5;

    logic                   en;
    logic [THR_W-1:0]       r_thr;
    logic                   r_sq_vld;
    logic [31:0]            r_sq;
    t_mat                   r_mat [SQRT_STEPS+1];
    logic                   sq_vld  [SQRT_STEPS+1];
    logic [31:0]            sq_n    [SQRT_STEPS+1];
    logic [SQ_REM_W-1:0]    sq_rem  [SQRT_STEPS+1];
    logic [15:0]            sq_root [SQRT_STEPS+1];
    t_mat                   in_mat;
    t_lane                  lane [NL][CORDIC_STAGES+1];
    logic                   r_cv [CORDIC_STAGES+1];
    logic signed [15:0]     n_ang [NL];
    logic signed [15:0]     n_mid;
    logic signed [16:0]     n_dist;
    logic [15:0]            n_first;
    logic [14:0]            n_middle;
    logic [15:0]            n_last;
    t_lock                  n_lock;
    logic [OUT_DATA_W-1:0]  r_out;
    logic                   r_out_vld;
    logic [1:0]             out_lock;
    logic                   out_locked;

    assign en         = !r_out_vld || i_m_tready;
    assign o_s_tready = en;

    // Configuration register
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_W'(1);
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_thr <= pwdata[THR_W-1:0];
        end
    end
    assign prdata = paddr[2] ? 32'd0 : 32'(r_thr);

    // Square and sum the column used for the middle angle
    assign in_mat = t_mat'({i_s_tdata[15:0], i_s_tdata[31:16], i_s_tdata[47:32],
                            i_s_tdata[63:48], i_s_tdata[79:64], i_s_tdata[95:80],
                            i_s_tdata[111:96]});
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld <= 1'b0;
        end else if (en) begin
            r_sq_vld <= i_s_tvalid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq     <= 32'(in_mat.m02 * in_mat.m02) + 32'(in_mat.m12 * in_mat.m12);
            r_mat[0] <= in_mat;
        end
    end

    // Square root chain, matrix carried alongside
    assign sq_vld[0]  = r_sq_vld;
    assign sq_n[0]    = r_sq;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        rmz_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_stage (SQRT_W'(SQRT_STEPS - 1 - k)),
            .i_vld   (sq_vld[k]),
            .i_n     (sq_n[k]),
            .i_rem   (sq_rem[k]),
            .i_root  (sq_root[k]),
            .o_vld   (sq_vld[k+1]),
            .o_n     (sq_n[k+1]),
            .o_rem   (sq_rem[k+1]),
            .o_root  (sq_root[k+1])
        );
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_mat[k+1] <= r_mat[k];
            end
        end
    end

    // Set up the five lanes: middle, first, last general, last near zero, last near pi
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv[0] <= 1'b0;
        end else if (en) begin
            r_cv[0] <= sq_vld[SQRT_STEPS];
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            lane[0][0] <= lane_init({1'b0, sq_root[SQRT_STEPS]},
                                    17'(r_mat[SQRT_STEPS].m22));
            lane[1][0] <= lane_init(17'(r_mat[SQRT_STEPS].m21), 17'(r_mat[SQRT_STEPS].m20));
            lane[2][0] <= lane_init(17'(r_mat[SQRT_STEPS].m12),
                                    -17'(r_mat[SQRT_STEPS].m02));
            lane[3][0] <= lane_init(-17'(r_mat[SQRT_STEPS].m10),
                                    17'(r_mat[SQRT_STEPS].m00));
            lane[4][0] <= lane_init(17'(r_mat[SQRT_STEPS].m10),
                                    -17'(r_mat[SQRT_STEPS].m00));
        end
    end

    // CORDIC cells, one row per lane
    for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_stage
        for (genvar l = 0; l < NL; l++) begin : g_lane
            rmz_cordic_cell u_cell (
                .i_clk   (i_clk),
                .i_en    (en),
                .i_stage (STAGE_W'(s)),
                .i_lane  (lane[l][s]),
                .o_lane  (lane[l][s+1])
            );
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cv[s+1] <= 1'b0;
            end else if (en) begin
                r_cv[s+1] <= r_cv[s];
            end
        end
    end

    // Round lanes, classify the lock window, pick the result
    always_comb begin
        for (int l = 0; l < NL; l++) begin
            n_ang[l] = lane_angle(lane[l][CORDIC_STAGES]);
        end
        n_mid  = (n_ang[0] < 16'sd0) ? 16'sd0 : n_ang[0];
        n_dist = 17'(PI_Q13) - 17'(n_mid);
        if (n_dist < 17'sd0)
            n_dist = -n_dist;
        if (n_mid < $signed({3'b000, r_thr})) begin
            n_first  = '0;
            n_middle = '0;
            n_last   = n_ang[3];
            n_lock   = LOCK_ZERO;
        end else if (n_dist < $signed({4'b0000, r_thr})) begin
            n_first  = '0;
            n_middle = PI_Q13[14:0];
            n_last   = n_ang[4];
            n_lock   = LOCK_PI;
        end else begin
            n_first  = n_ang[1];
            n_middle = n_mid[14:0];
            n_last   = n_ang[2];
            n_lock   = LOCK_NONE;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_cv[CORDIC_STAGES];
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= OUT_DATA_W'({n_lock, n_last, n_middle, n_first});
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out;

    // Fields of the waiting result for the checks below
    assign out_lock   = o_m_tdata[48:47];
    assign out_locked = o_m_tvalid && (out_lock != LOCK_NONE);

    `RMZ_ASSERT(a_lock_code, o_m_tvalid |-> (out_lock <= LOCK_PI), "bad lock code")
    `RMZ_ASSERT(a_lock_first, out_locked |-> (o_m_tdata[15:0] == '0), "first angle set while locked")
    `RMZ_ASSERT(a_mid_range, o_m_tvalid |-> (o_m_tdata[30:16] <= PI_Q13[14:0]), "middle angle beyond pi")
    `RMZ_ASSERT_ALWAYS(a_rst_idle, !i_rst_n |=> !o_m_tvalid, "output valid after reset")
endmodule

FILE: hdl/rmz_sqrt_cell.sv
// One digit cell of the integer square root chain: two radicand bits a cycle while enabled.
// Depends on rmz_pkg.
module rmz_sqrt_cell (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic [rmz_pkg::SQRT_W-1:0]      i_stage,
    input  logic                            i_vld,
    input  logic [31:0]                     i_n,
    input  logic [rmz_pkg::SQ_REM_W-1:0]    i_rem,
    input  logic [15:0]                     i_root,
    output logic                            o_vld,
    output logic [31:0]                     o_n,
    output logic [rmz_pkg::SQ_REM_W-1:0]    o_rem,
    output logic [15:0]                     o_root
);
    import rmz_pkg::*;

    logic [SQ_REM_W+1:0]     n_trial;
    logic [SQ_REM_W+2:0]     n_diff;
    logic [SQ_REM_W-1:0]     n_rem;
    logic [15:0]             n_root;
    logic                    r_vld;
    logic [31:0]             r_n;
    logic [SQ_REM_W-1:0]     r_rem;
    logic [15:0]             r_root;

    // Try the next root bit against the remainder
    always_comb begin
        n_trial = {i_rem, i_n[{i_stage, 1'b0} +: 2]};
        n_diff  = {1'b0, n_trial} - (SQ_REM_W+3)'({i_root, 2'b01});
        if (!n_diff[SQ_REM_W+2]) begin
            n_rem  = n_diff[SQ_REM_W-1:0];
            n_root = {i_root[14:0], 1'b1};
        end else begin
            n_rem  = n_trial[SQ_REM_W-1:0];
            n_root = {i_root[14:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n    <= i_n;
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_vld  = r_vld;
    assign o_n    = r_n;
    assign o_rem  = r_rem;
    assign o_root = r_root;
endmodule

FILE: hdl/rmz_cordic_cell.sv
// One vectoring micro-rotation of a CORDIC lane, registered.
// Depends on rmz_pkg.
module rmz_cordic_cell (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [rmz_pkg::STAGE_W-1:0]    i_stage,
    input  rmz_pkg::t_lane                 i_lane,
    output rmz_pkg::t_lane                 o_lane
);
    import rmz_pkg::*;

    logic signed [XY_W-1:0] n_dx;
    logic signed [XY_W-1:0] n_dy;
    t_lane                  n_lane;
    t_lane                  r_lane;

    // Rotate toward the x axis by the step angle
    always_comb begin
        n_dx        = i_lane.y >>> i_stage;
        n_dy        = i_lane.x >>> i_stage;
        n_lane.zero = i_lane.zero;
        if (i_lane.y >= 0) begin
            n_lane.x = i_lane.x + n_dx;
            n_lane.y = i_lane.y - n_dy;
            n_lane.z = i_lane.z + atan_step(i_stage);
        end else begin
            n_lane.x = i_lane.x - n_dx;
            n_lane.y = i_lane.y + n_dy;
            n_lane.z = i_lane.z - atan_step(i_stage);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;
endmodule

FILE: tb/tb_top.sv
// Testbench for rotation_matrix_to_zyz_euler: random and corner matrices, scoreboard check.
// Depends on rmz_pkg and the RTL top level only; predicts angles with its own CORDIC model.
`timescale 1ns / 100ps
module tb_top;
    import rmz_pkg::*;

    // Result fields from the lowest bit up: first, middle, last, lock
    typedef struct packed {
        logic        [1:0]  lock;
        logic signed [15:0] last;
        logic        [14:0] middle;
        logic signed [15:0] first;
    } t_angles;

    localparam int PIPE_LAT  = 3 + 16 + CORDIC_STAGES;
    localparam int WDOG_MAX  = 4000;
    localparam int STALL_LEN = 150;
    localparam logic [2:0] ADDR_LOCK_THR = 3'd0;

    logic i_clk, i_rst_n;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tvalid, s_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tvalid, m_tready;
    logic psel, penable, pwrite, pready;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;

    rotation_matrix_to_zyz_euler dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tdata(s_tdata), .i_s_tvalid(s_tvalid), .o_s_tready(s_tready),
        .o_m_tdata(m_tdata), .o_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    t_mat    pending_mats[$];
    t_angles expected_angles[$];
    logic [12:0] lock_thr;
    int  n_errors;
    int  idle_cycles;
    bit  stall_req;
    int  stall_cnt;
    bit  s_taken;
    int  gap_left, burst_left;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // CORDIC atan2 in Q2.13, saturated
    function automatic logic signed [15:0] cordic_atan2(input longint y0, input longint x0);
        longint x, y, z, dx, dy, q;
        longint steps[24] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
                              4096, 2048, 1024, 512, 256, 128, 64, 32,
                              16, 8, 4, 2, 1, 0, 0, 0};
        if (x0 == 0 && y0 == 0) return 16'sd0;
        x = x0 * 256;
        y = y0 * 256;
        z = 0;
        if (x < 0) begin
            z = (y >= 0) ? 3294199 : -3294199;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; z += steps[i];
            end else begin
                x -= dx; y += dy; z -= steps[i];
            end
        end
        q = (z + 64) >>> 7;
        if (q > 25736) q = 25736;
        if (q < -25736) q = -25736;
        return 16'(q);
    endfunction

    // Predict the Euler angles of one matrix
    function automatic t_angles predict_angles(input t_mat m);
        t_angles a;
        longint sumsq, root, mid, pi_gap;
        sumsq = longint'(m.m02) * m.m02 + longint'(m.m12) * m.m12;
        root = 0;
        while ((root + 1) * (root + 1) <= sumsq) root++;
        mid = cordic_atan2(root, m.m22);
        if (mid < 0) mid = 0;
        pi_gap = 25736 - mid;
        if (pi_gap < 0) pi_gap = -pi_gap;
        if (mid < lock_thr) begin
            a.first = 0; a.middle = 0;
            a.last = cordic_atan2(-longint'(m.m10), m.m00);
            a.lock = LOCK_ZERO;
        end else if (pi_gap < lock_thr) begin
            a.first = 0; a.middle = 15'd25736;
            a.last = cordic_atan2(m.m10, -longint'(m.m00));
            a.lock = LOCK_PI;
        end else begin
            a.first = cordic_atan2(m.m21, m.m20);
            a.middle = 15'(mid);
            a.last = cordic_atan2(m.m12, -longint'(m.m02));
            a.lock = LOCK_NONE;
        end
        return a;
    endfunction

    function automatic logic [IN_DATA_W-1:0] pack_mat(input t_mat m);
        return {m.m22, m.m21, m.m20, m.m12, m.m10, m.m02, m.m00};
    endfunction

    function automatic logic signed [15:0] rand_elem();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'($urandom);
        if (r == 1) return ($urandom_range(0, 1) == 1) ? 16'sd16384 : -16'sd16384;
        if (r == 2) return 16'sd0;
        return 16'($signed($urandom_range(0, 32768)) - 16384);
    endfunction

    // Random matrix; kind 1 gives a near-axis third column to reach the lock windows
    function automatic t_mat rand_mat(input int kind);
        t_mat m;
        m.m00 = rand_elem(); m.m02 = rand_elem(); m.m10 = rand_elem();
        m.m12 = rand_elem(); m.m20 = rand_elem(); m.m21 = rand_elem();
        m.m22 = rand_elem();
        if (kind == 1) begin
            m.m02 = 16'($signed($urandom_range(0, 40)) - 20);
            m.m12 = 16'($signed($urandom_range(0, 40)) - 20);
            m.m22 = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
        end
        return m;
    endfunction

    // Send: bursts and gaps, driven at the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_taken) begin
            s_taken = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pending_mats.size() > 0) begin
                s_tdata  <= pack_mat(pending_mats[0]);
                s_tvalid <= 1'b1;
                if (burst_left > 0) burst_left--;
                else begin
                    burst_left = $urandom_range(0, 30);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Record expectations at accept time and retire the sent matrix
    always @(posedge i_clk) begin
        if (i_rst_n && s_tvalid && s_tready) begin
            expected_angles.push_back(predict_angles(pending_mats.pop_front()));
            s_taken = 1'b1;
        end
    end

    // Receiver stall pattern, with a long hold-off on request
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (stall_cnt > 0) begin
            stall_cnt--;
            m_tready <= 1'b0;
        end else if (stall_req) begin
            stall_req = 1'b0;
            stall_cnt = STALL_LEN;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 7) != 0) || ($urandom_range(0, 1) == 0);
        end
    end

    // Compare results with the oldest expectation
    always @(posedge i_clk) begin
        t_angles got, want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = t_angles'(m_tdata[48:0]);
            if (expected_angles.size() == 0) begin
                $error("unexpected result transaction %h", m_tdata);
                n_errors++;
            end else begin
                want = expected_angles.pop_front();
                if (got.first !== want.first) begin
                    $error("first_angle expected %0d got %0d", want.first, got.first);
                    n_errors++;
                end
                if (got.middle !== want.middle) begin
                    $error("middle_angle expected %0d got %0d", want.middle, got.middle);
                    n_errors++;
                end
                if (got.last !== want.last) begin
                    $error("last_angle expected %0d got %0d", want.last, got.last);
                    n_errors++;
                end
                if (got.lock !== want.lock) begin
                    $error("lock_case expected %0d got %0d", want.lock, got.lock);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WDOG_MAX) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        lock_thr = data[12:0];
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic drain_pipe();
        while (pending_mats.size() > 0 || expected_angles.size() > 0) @(posedge i_clk);
        repeat (PIPE_LAT + 5) @(posedge i_clk);
    endtask

    task automatic queue_corners();
        t_mat m;
        logic signed [15:0] ext[3] = '{16'sd16384, -16'sd16384, 16'sd0};
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                m = '{m00: ext[i], m02: ext[j], m10: ext[j], m12: ext[i],
                      m20: ext[i], m21: ext[j], m22: ext[(i + j) % 3]};
                pending_mats.push_back(m);
            end
        end
        // Identity and other axis-aligned cases: locked near zero and near pi
        pending_mats.push_back('{16'sd16384, 16'sd0, 16'sd0, 16'sd0,
                                 16'sd0, 16'sd0, 16'sd16384});
        pending_mats.push_back('{16'sd16384, 16'sd0, 16'sd0, 16'sd0,
                                 16'sd0, 16'sd0, -16'sd16384});
        pending_mats.push_back('{-16'sd16384, 16'sd0, 16'sd0, 16'sd0,
                                 16'sd0, 16'sd0, -16'sd16384});
        pending_mats.push_back('{-16'sd16384, 16'sd0, 16'sd5, 16'sd0,
                                 16'sd0, 16'sd0, 16'sd16384});
        // Zero vector and extreme raw bits
        pending_mats.push_back('0);
        pending_mats.push_back('{16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                                 16'h7fff, 16'h8000, 16'h7fff});
        pending_mats.push_back('{16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
                                 16'h8000, 16'h7fff, 16'h8000});
        pending_mats.push_back('{16'hffff, 16'hffff, 16'hffff, 16'hffff,
                                 16'hffff, 16'hffff, 16'hffff});
    endtask

    // Stimulus and end of run
    initial begin
        logic [12:0] thr_set[5] = '{13'd0, 13'd8191, 13'd40, 13'd1, 13'd300};
        i_rst_n = 1'b0; s_tvalid = 1'b0; s_tdata = '0; m_tready = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        n_errors = 0; idle_cycles = 0; stall_req = 1'b0; stall_cnt = 0; s_taken = 1'b0;
        gap_left = 0; burst_left = 0; lock_thr = 13'd1;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        queue_corners();
        drain_pipe();
        foreach (thr_set[p]) begin
            apb_write(ADDR_LOCK_THR, {19'd0, thr_set[p]});
            if (p == 1 || p == 4) queue_corners();
            for (int k = 0; k < 270; k++)
                pending_mats.push_back(rand_mat($urandom_range(0, 2) == 0));
            // Hold the output off long enough to back the pipe up
            if (p == 2) stall_req = 1'b1;
            drain_pipe();
        end

        if (n_errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
